// File: design/arcs_pkg.sv
// Shared types and codes for the aligned read chunk sequencer.
// Used by the front, back, output stage, top level and checker; depends on nothing.
package arcs_pkg;

	// Command codes on the input channel
	localparam logic [1:0] CMD_START    = 2'd0;
	localparam logic [1:0] CMD_COMPLETE = 2'd1;
	localparam logic [1:0] CMD_FAIL     = 2'd2;

	// Request status codes on the result channel
	localparam logic [1:0] ST_ACTIVE    = 2'd0;
	localparam logic [1:0] ST_COMPLETED = 2'd1;
	localparam logic [1:0] ST_FAILED    = 2'd2;
	localparam logic [1:0] ST_REJECTED  = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_CACHE_SIZE   = 2'd0;
	localparam logic [1:0] REG_OFFSET_ALIGN = 2'd1;
	localparam logic [1:0] REG_LENGTH_ALIGN = 2'd2;

	localparam logic [20:0] MAX_CHUNK   = 21'd1048576;
	localparam logic [20:0] CACHE_RESET = 21'd32768;

	// Command class decided by the front
	typedef enum logic [2:0] {
		K_START,
		K_BAD_START,
		K_COMPLETE,
		K_FAIL,
		K_ILLEGAL
	} kind_t;

	// Result shape decided by the back
	typedef enum logic [2:0] {
		R_REJECT,
		R_FAIL,
		R_ISSUE,
		R_COPY_ISSUE,
		R_COPY_DONE
	} res_t;

	typedef struct packed {
		res_t res;
		logic direct;
	} res_ctl_t;

endpackage

// File: design/arcs_fifo.sv
// Two-entry transaction queue between the front and the back.
// Generic payload width; no package dependency.
module arcs_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);
	localparam int DEPTH = 2;
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign full      = (count_q == (PW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: design/arcs_front.sv
// Front: decodes a command and checks a start request against the file length.
// Precomputes the first chunk's alignment pull-back; depends on arcs_pkg.
module arcs_front #(
	parameter int AW = 32,
	parameter int CW = 33
) (
	input  logic [1:0]      command,
	input  logic [31:0]     request_offset,
	input  logic [31:0]     request_length,
	input  logic [31:0]     file_length,
	input  logic            direct_transfer,
	input  logic [15:0]     oa_mask,
	output arcs_pkg::kind_t kind,
	output logic [AW-1:0]   base,
	output logic [AW-1:0]   total,
	output logic [CW-1:0]   rem0,
	output logic [CW-1:0]   tot0,
	output logic [15:0]     adj,
	output logic            direct
);
	import arcs_pkg::*;

	logic [AW-1:0] ro;
	logic [AW-1:0] rl;
	logic [AW-1:0] fl;
	logic [AW-1:0] room;
	logic          start_ok;

	assign ro   = request_offset[AW-1:0];
	assign rl   = request_length[AW-1:0];
	assign fl   = file_length[AW-1:0];
	assign room = fl - ro;

	// Nonempty, starts inside the file, and ends no later than end of file
	assign start_ok = (rl != '0) && (ro < fl) && (rl <= room);

	assign adj    = ro[15:0] & oa_mask;
	assign base   = ro;
	assign total  = rl;
	assign rem0   = CW'(room) + CW'(adj);
	assign tot0   = CW'(rl) + CW'(adj);
	assign direct = direct_transfer;

	always_comb begin
		case (command)
			CMD_START:    kind = start_ok ? K_START : K_BAD_START;
			CMD_COMPLETE: kind = K_COMPLETE;
			CMD_FAIL:     kind = K_FAIL;
			default:      kind = K_ILLEGAL;
		endcase
	end

endmodule

// File: design/arcs_back.sv
// Back: holds the request state and advances it by one transaction per cycle
// unless stage 1 stalls. Tracks chunk offset, bytes left in the request and
// bytes left to end of file; depends on arcs_pkg.
module arcs_back #(
	parameter int AW = 32,
	parameter int CW = 33
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [20:0]        eff_cache,
	input  logic               entry_valid,
	input  arcs_pkg::kind_t    kind,
	input  logic [AW-1:0]      base,
	input  logic [AW-1:0]      total,
	input  logic [CW-1:0]      rem0,
	input  logic [CW-1:0]      tot0,
	input  logic [15:0]        adj,
	input  logic               direct,
	output logic               pop,
	output logic               valid_s1,
	input  logic               s1_ready,
	output arcs_pkg::res_ctl_t ctl_s1,
	output logic [CW-1:0]      old_co_s1,
	output logic [20:0]        old_cl_s1,
	output logic [CW-1:0]      old_tot_rem_s1,
	output logic [AW-1:0]      total_s1,
	output logic [AW-1:0]      base_q,
	output logic [CW-1:0]      co_q,
	output logic [20:0]        cl_q,
	output logic [CW-1:0]      rem_eof_q
);
	import arcs_pkg::*;

	logic          busy_q;
	logic [AW-1:0] total_q;
	logic [CW-1:0] tot_rem_q;
	logic          direct_q;

	logic [CW-1:0] rem_after;
	logic [CW-1:0] rem_sel;
	logic [20:0]   cl_new;
	logic          cpl_done;
	res_t          res;
	logic          start_go;
	logic          cpl_next;
	logic          go_idle;

	assign pop       = entry_valid && (!valid_s1 || s1_ready);
	assign cpl_done  = (CW'(cl_q) >= tot_rem_q);
	assign rem_after = rem_eof_q - CW'(cl_q);
	assign rem_sel   = (kind == K_START) ? rem0 : rem_after;
	// Clip the next chunk at end of file
	assign cl_new    = (rem_sel < CW'(eff_cache)) ? rem_sel[20:0] : eff_cache;

	always_comb begin
		res      = R_REJECT;
		start_go = 1'b0;
		cpl_next = 1'b0;
		go_idle  = 1'b0;
		case (kind)
			K_START: begin
				if (!busy_q) begin
					res      = R_ISSUE;
					start_go = 1'b1;
				end
			end
			K_COMPLETE: begin
				if (busy_q) begin
					if (cpl_done) begin
						res     = R_COPY_DONE;
						go_idle = 1'b1;
					end else begin
						res      = R_COPY_ISSUE;
						cpl_next = 1'b1;
					end
				end
			end
			K_FAIL: begin
				if (busy_q) begin
					res     = R_FAIL;
					go_idle = 1'b1;
				end
			end
			default: res = R_REJECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (pop && start_go)
				busy_q <= 1'b1;
			else if (pop && go_idle)
				busy_q <= 1'b0;
			if (pop)
				valid_s1 <= 1'b1;
			else if (s1_ready)
				valid_s1 <= 1'b0;
		end
	end

	// The output stage reads the request state while stage 1 holds; the state
	// only moves on a pop, which is also the edge stage 1 hands its transaction on.
	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_s1         <= '{res: res, direct: direct_q};
			old_co_s1      <= co_q;
			old_cl_s1      <= cl_q;
			old_tot_rem_s1 <= tot_rem_q;
			total_s1       <= total_q;
			if (start_go) begin
				base_q    <= base;
				total_q   <= total;
				direct_q  <= direct;
				co_q      <= {CW{1'b0}} - CW'(adj);
				tot_rem_q <= tot0;
				rem_eof_q <= rem0;
				cl_q      <= cl_new;
			end else if (cpl_next) begin
				co_q      <= co_q + CW'(cl_q);
				tot_rem_q <= tot_rem_q - CW'(cl_q);
				rem_eof_q <= rem_after;
				cl_q      <= cl_new;
			end
		end
	end

endmodule

// File: design/arcs_out.sv
// Output stage: forms the copy descriptor and the device read, and holds the
// result in an output register. Depends on arcs_pkg.
module arcs_out #(
	parameter int AW = 32,
	parameter int CW = 33
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        la_mask,
	input  logic               valid_s1,
	output logic               s1_ready,
	input  arcs_pkg::res_ctl_t ctl_s1,
	input  logic [CW-1:0]      old_co_s1,
	input  logic [20:0]        old_cl_s1,
	input  logic [CW-1:0]      old_tot_rem_s1,
	input  logic [AW-1:0]      total_s1,
	input  logic [AW-1:0]      base_q,
	input  logic [CW-1:0]      co_q,
	input  logic [20:0]        cl_q,
	input  logic [CW-1:0]      rem_eof_q,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               read_valid,
	output logic [31:0]        read_offset,
	output logic [20:0]        read_length,
	output logic               copy_valid,
	output logic [15:0]        copy_skip,
	output logic [31:0]        copy_dest_offset,
	output logic [20:0]        copy_count,
	output logic               request_done,
	output logic [1:0]         request_status
);
	import arcs_pkg::*;

	logic          out_valid_q;
	logic          read_valid_q;
	logic [31:0]   read_offset_q;
	logic [20:0]   read_length_q;
	logic          copy_valid_q;
	logic [15:0]   copy_skip_q;
	logic [31:0]   copy_dest_offset_q;
	logic [20:0]   copy_count_q;
	logic          request_done_q;
	logic [1:0]    request_status_q;

	logic          take;
	logic [CW-1:0] pos;
	logic [20:0]   rnd;
	logic [20:0]   rnd_m;
	logic [20:0]   sat;
	logic [20:0]   len;
	logic          co_neg;
	logic [CW-1:0] dlv;
	logic          dlv_pos;
	logic [CW-1:0] total_w;
	logic [20:0]   cnt_neg;
	logic [20:0]   cnt_pos;
	logic [20:0]   count;
	logic [15:0]   skip;
	logic [31:0]   dest;

	logic          rd_v;
	logic [31:0]   rd_off;
	logic [20:0]   rd_len;
	logic          cp_v;
	logic [15:0]   cp_skip;
	logic [31:0]   cp_dest;
	logic [20:0]   cp_count;
	logic          done;
	logic [1:0]    status;

	assign s1_ready = !out_valid_q || out_ready;
	assign take     = valid_s1 && s1_ready;

	// Device read from the updated state: round up, saturate, clip at end of file
	assign pos   = CW'(base_q) + co_q;
	assign rnd   = cl_q + {5'd0, la_mask};
	assign rnd_m = rnd & ~{5'd0, la_mask};
	assign sat   = (rnd_m > MAX_CHUNK) ? MAX_CHUNK : rnd_m;
	assign len   = (CW'(sat) > rem_eof_q) ? rem_eof_q[20:0] : sat;

	// Copy descriptor from the state before the completion
	assign co_neg  = old_co_s1[CW-1];
	assign dlv     = old_co_s1 + CW'(old_cl_s1);
	assign dlv_pos = !dlv[CW-1] && (dlv != '0);
	assign total_w = CW'(total_s1);
	assign cnt_neg = (dlv > total_w) ? total_w[20:0] : dlv[20:0];
	assign cnt_pos = (CW'(old_cl_s1) > old_tot_rem_s1) ? old_tot_rem_s1[20:0] : old_cl_s1;

	always_comb begin
		skip  = '0;
		dest  = '0;
		count = '0;
		if (co_neg) begin
			if (dlv_pos) begin
				skip  = 16'({CW{1'b0}} - old_co_s1);
				count = cnt_neg;
			end
		end else begin
			dest  = 32'(old_co_s1[AW-1:0]);
			count = cnt_pos;
		end
	end

	always_comb begin
		rd_v     = 1'b0;
		rd_off   = '0;
		rd_len   = '0;
		cp_v     = 1'b0;
		cp_skip  = '0;
		cp_dest  = '0;
		cp_count = '0;
		done     = 1'b0;
		status   = ST_REJECTED;
		case (ctl_s1.res)
			R_ISSUE: begin
				rd_v   = 1'b1;
				rd_off = 32'(pos[AW-1:0]);
				rd_len = len;
				status = ST_ACTIVE;
			end
			R_COPY_ISSUE: begin
				rd_v     = 1'b1;
				rd_off   = 32'(pos[AW-1:0]);
				rd_len   = len;
				cp_v     = !ctl_s1.direct && (count != '0);
				cp_skip  = skip;
				cp_dest  = dest;
				cp_count = count;
				status   = ST_ACTIVE;
			end
			R_COPY_DONE: begin
				cp_v     = !ctl_s1.direct && (count != '0);
				cp_skip  = skip;
				cp_dest  = dest;
				cp_count = count;
				done     = 1'b1;
				status   = ST_COMPLETED;
			end
			R_FAIL: begin
				done   = 1'b1;
				status = ST_FAILED;
			end
			default: status = ST_REJECTED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_ready)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			read_valid_q       <= rd_v;
			read_offset_q      <= rd_off;
			read_length_q      <= rd_len;
			copy_valid_q       <= cp_v;
			copy_skip_q        <= cp_skip;
			copy_dest_offset_q <= cp_dest;
			copy_count_q       <= cp_count;
			request_done_q     <= done;
			request_status_q   <= status;
		end
	end

	assign out_valid        = out_valid_q;
	assign read_valid       = read_valid_q;
	assign read_offset      = read_offset_q;
	assign read_length      = read_length_q;
	assign copy_valid       = copy_valid_q;
	assign copy_skip        = copy_skip_q;
	assign copy_dest_offset = copy_dest_offset_q;
	assign copy_count       = copy_count_q;
	assign request_done     = request_done_q;
	assign request_status   = request_status_q;

endmodule

// File: design/aligned_read_chunk_sequencer.sv
// Aligned read chunk sequencer: top level with configuration registers.
// A result passes through the queue, the stage 1 registers and the output register.
// Throughput: one command per cycle while out_ready holds; the back updates the
// request state as it takes each command and the 2-entry queue plus the output register absorb stalls.
// Reset: idle, queue and output empty, cache size 32768, no alignment.
module aligned_read_chunk_sequencer #(
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] request_offset,
	input  logic [31:0] request_length,
	input  logic [31:0] file_length,
	input  logic        direct_transfer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        read_valid,
	output logic [31:0] read_offset,
	output logic [20:0] read_length,
	output logic        copy_valid,
	output logic [15:0] copy_skip,
	output logic [31:0] copy_dest_offset,
	output logic [20:0] copy_count,
	output logic        request_done,
	output logic [1:0]  request_status
);
	import arcs_pkg::*;

	localparam int AW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
	// Wide enough for a full chunk length plus a sign bit at any offset width
	localparam int CW = ((AW > 21) ? AW : 21) + 1;

	typedef struct packed {
		kind_t         kind;
		logic [AW-1:0] base;
		logic [AW-1:0] total;
		logic [CW-1:0] rem0;
		logic [CW-1:0] tot0;
		logic [15:0]   adj;
		logic          direct;
	} entry_t;

	function automatic logic [20:0] clamp_cache(input logic [20:0] c);
		if (c == '0)
			return 21'd1;
		else if (c > MAX_CHUNK)
			return MAX_CHUNK;
		else
			return c;
	endfunction

	function automatic logic [15:0] align_mask(input logic [16:0] a);
		if (a == '0)
			return '0;
		else if (a[16])
			return 16'hFFFF;
		else
			return a[15:0] - 16'd1;
	endfunction

	logic [20:0] eff_cache_q;
	logic [15:0] oa_mask_q;
	logic [15:0] la_mask_q;

	entry_t entry_in;
	entry_t entry_out;
	logic   [$bits(entry_t)-1:0] pop_data;
	logic   full;
	logic   not_empty;
	logic   pop;

	logic          valid_s1;
	logic          s1_ready;
	res_ctl_t      ctl_s1;
	logic [CW-1:0] old_co_s1;
	logic [20:0]   old_cl_s1;
	logic [CW-1:0] old_tot_rem_s1;
	logic [AW-1:0] total_s1;
	logic [AW-1:0] base_q;
	logic [CW-1:0] co_q;
	logic [20:0]   cl_q;
	logic [CW-1:0] rem_eof_q;

	assign cfg_ready = 1'b1;

	// Store registers in effective form: clamped cache size and alignment masks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_cache_q <= CACHE_RESET;
			oa_mask_q   <= '0;
			la_mask_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CACHE_SIZE:   eff_cache_q <= clamp_cache(cfg_data);
				REG_OFFSET_ALIGN: oa_mask_q   <= align_mask(cfg_data[16:0]);
				REG_LENGTH_ALIGN: la_mask_q   <= align_mask(cfg_data[16:0]);
				default: ;
			endcase
		end
	end

	assign in_ready = !full;

	arcs_front #(.AW(AW), .CW(CW)) u_front (
		.command         (command),
		.request_offset  (request_offset),
		.request_length  (request_length),
		.file_length     (file_length),
		.direct_transfer (direct_transfer),
		.oa_mask         (oa_mask_q),
		.kind            (entry_in.kind),
		.base            (entry_in.base),
		.total           (entry_in.total),
		.rem0            (entry_in.rem0),
		.tot0            (entry_in.tot0),
		.adj             (entry_in.adj),
		.direct          (entry_in.direct)
	);

	arcs_fifo #(.WIDTH($bits(entry_t))) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !full),
		.push_data (entry_in),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	assign entry_out = entry_t'(pop_data);

	arcs_back #(.AW(AW), .CW(CW)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.eff_cache      (eff_cache_q),
		.entry_valid    (not_empty),
		.kind           (entry_out.kind),
		.base           (entry_out.base),
		.total          (entry_out.total),
		.rem0           (entry_out.rem0),
		.tot0           (entry_out.tot0),
		.adj            (entry_out.adj),
		.direct         (entry_out.direct),
		.pop            (pop),
		.valid_s1       (valid_s1),
		.s1_ready       (s1_ready),
		.ctl_s1         (ctl_s1),
		.old_co_s1      (old_co_s1),
		.old_cl_s1      (old_cl_s1),
		.old_tot_rem_s1 (old_tot_rem_s1),
		.total_s1       (total_s1),
		.base_q         (base_q),
		.co_q           (co_q),
		.cl_q           (cl_q),
		.rem_eof_q      (rem_eof_q)
	);

	arcs_out #(.AW(AW), .CW(CW)) u_out (
		.clk              (clk),
		.arst_n           (arst_n),
		.la_mask          (la_mask_q),
		.valid_s1         (valid_s1),
		.s1_ready         (s1_ready),
		.ctl_s1           (ctl_s1),
		.old_co_s1        (old_co_s1),
		.old_cl_s1        (old_cl_s1),
		.old_tot_rem_s1   (old_tot_rem_s1),
		.total_s1         (total_s1),
		.base_q           (base_q),
		.co_q             (co_q),
		.cl_q             (cl_q),
		.rem_eof_q        (rem_eof_q),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.read_valid       (read_valid),
		.read_offset      (read_offset),
		.read_length      (read_length),
		.copy_valid       (copy_valid),
		.copy_skip        (copy_skip),
		.copy_dest_offset (copy_dest_offset),
		.copy_count       (copy_count),
		.request_done     (request_done),
		.request_status   (request_status)
	);

endmodule

// File: design/arcs_checker.sv
// Port-level checks on the result channel of the sequencer, and the bind that
// attaches them to the top level. Depends on arcs_pkg.
module arcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        read_valid,
	input logic [31:0] read_offset,
	input logic [20:0] read_length,
	input logic        copy_valid,
	input logic [15:0] copy_skip,
	input logic [31:0] copy_dest_offset,
	input logic [20:0] copy_count,
	input logic        request_done,
	input logic [1:0]  request_status
);
	import arcs_pkg::*;

	// A rejected transaction carries nothing but its status
	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_status == ST_REJECTED |->
			!read_valid && !copy_valid && !request_done
			&& read_length == '0 && copy_count == '0)
		else $error("rejected transaction carries payload");

	// An issued read is never empty and only happens on an active request
	a_read_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |->
			read_length != '0 && request_status == ST_ACTIVE && !request_done)
		else $error("read issued on a finished request or with zero length");

	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_done |->
			(request_status == ST_COMPLETED || request_status == ST_FAILED))
		else $error("request done with wrong status");

	// A skip only comes from the pulled-back first chunk, which lands at offset zero
	a_skip_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && copy_skip != '0 |-> copy_dest_offset == '0 && copy_count != '0)
		else $error("buffer skip outside the first delivered chunk");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(read_offset) && $stable(copy_count)
			&& $stable(request_status))
		else $error("stalled result changed");

endmodule

bind aligned_read_chunk_sequencer arcs_checker u_arcs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.read_valid       (read_valid),
	.read_offset      (read_offset),
	.read_length      (read_length),
	.copy_valid       (copy_valid),
	.copy_skip        (copy_skip),
	.copy_dest_offset (copy_dest_offset),
	.copy_count       (copy_count),
	.request_done     (request_done),
	.request_status   (request_status)
);
